>>> rtl/core/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic [0:0] {
        CMD_PUT = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                  command;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
    } rsp_t;

endpackage

>>> rtl/core/lkv_store.sv
`timescale 1ns / 1ps

module lkv_store
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  req_t             req,
    input  logic [CAP_W-1:0] capacity,
    output rsp_t             rsp
);

    logic                  valid_reg [ENTRIES];
    logic                  valid_next[ENTRIES];
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [KEY_BITS-1:0]   key_next  [ENTRIES];
    logic [VALUE_BITS-1:0] data_reg  [ENTRIES];
    logic [VALUE_BITS-1:0] data_next [ENTRIES];
    logic [AGE_W-1:0]      age_reg   [ENTRIES];
    logic [AGE_W-1:0]      age_next  [ENTRIES];
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;

    logic [CNT_W-1:0] eff_cap;
    logic [AGE_W-1:0] last_age;
    logic [ENTRIES-1:0] match;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] old_idx;
    logic [IDX_W-1:0] free_idx;
    logic             have_free;
    logic             full;

    always_comb
    begin
        if (capacity == '0)
            eff_cap = CNT_W'(1);
        else if (int'(capacity) > ENTRIES)
            eff_cap = CNT_W'(ENTRIES);
        else
            eff_cap = CNT_W'(capacity);
    end

    // valid entries hold distinct ranks 0 .. fill-1, so the oldest has rank fill-1
    assign last_age = AGE_W'(fill_reg - CNT_W'(1));
    assign full     = (fill_reg >= eff_cap);
    assign hit      = |match;

    always_comb
    begin
        hit_idx   = '0;
        old_idx   = '0;
        free_idx  = '0;
        have_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match[i])
                hit_idx = IDX_W'(i);
            if (valid_reg[i] && (age_reg[i] == last_age))
                old_idx = IDX_W'(i);
            if (!valid_reg[i])
            begin
                free_idx  = IDX_W'(i);
                have_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            data_next[i]  = data_reg[i];
            age_next[i]   = age_reg[i];
        end
        fill_next      = fill_reg;
        rsp.found      = 1'b1;
        rsp.read_value = '0;

        if (go)
        begin
            case (req.command)
                CMD_GET:
                begin
                    rsp.found = hit;
                    if (hit)
                    begin
                        rsp.read_value = data_reg[hit_idx];
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && (age_reg[i] < age_reg[hit_idx]))
                                age_next[i] = age_reg[i] + AGE_W'(1);
                        age_next[hit_idx] = '0;
                    end
                end
                CMD_PUT:
                begin
                    if (hit)
                    begin
                        data_next[hit_idx] = req.value;
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && (age_reg[i] < age_reg[hit_idx]))
                                age_next[i] = age_reg[i] + AGE_W'(1);
                        age_next[hit_idx] = '0;
                        // capacity was lowered: drop the oldest after the touch
                        if (fill_reg > eff_cap)
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (valid_reg[i] && (age_next[i] == last_age)
                                    && (IDX_W'(i) != hit_idx))
                                    valid_next[i] = 1'b0;
                            fill_next = fill_reg - CNT_W'(1);
                        end
                    end
                    else if (full)
                    begin
                        key_next[old_idx]  = req.key;
                        data_next[old_idx] = req.value;
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && (age_reg[i] < age_reg[old_idx]))
                                age_next[i] = age_reg[i] + AGE_W'(1);
                        age_next[old_idx] = '0;
                    end
                    else if (have_free)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i])
                                age_next[i] = age_reg[i] + AGE_W'(1);
                        valid_next[free_idx] = 1'b1;
                        key_next[free_idx]   = req.key;
                        data_next[free_idx]  = req.value;
                        age_next[free_idx]   = '0;
                        fill_next            = fill_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp.found = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= valid_next[i];
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]  <= key_next[i];
            data_reg[i] <= data_next[i];
            age_reg[i]  <= age_next[i];
        end
    end

endmodule

>>> rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps

// LRU key/value cache, fully associative, parallel key compare over all entries.
// Handshake: start -> go_reg -> done_reg; done is high for one cycle per word.
// Throughput: one word per cycle; busy is never raised, the receiver cannot stall.
// Reset (rst_n, async low): all entries invalid, fill count zero, capacity 8.

module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic             go_reg;
    req_t             req_reg;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [CAP_W-1:0] cap_reg;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            go_reg   <= start && !busy;
            done_reg <= go_reg;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
        if (go_reg)
            rsp_reg <= rsp_next;
    end

    lkv_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .req      (req_reg),
        .capacity (cap_reg),
        .rsp      (rsp_next)
    );

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |=> done_reg)
        else $error("accepted word produced no result");

    a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
        (go_reg && (req_reg.command == CMD_PUT)) |=> (rsp.found && (rsp.read_value == '0)))
        else $error("put result must be found with zero data");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !rsp.found) |-> (rsp.read_value == '0))
        else $error("miss returned nonzero data");

endmodule

>>> tb/lkv_checker.sv
`timescale 1ns / 1ps

module lkv_checker
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  req_t             req,
    input  logic             done,
    input  rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output int               errors,
    output int               pending
);

    logic                  slot_valid [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_data  [ENTRIES];
    int unsigned           slot_rank  [ENTRIES];
    int unsigned           slot_fill;
    logic [CAP_W-1:0]      cap_reg;

    rsp_t rsp_due[$];
    rsp_t due_word;
    int   fail_count = 0;
    int   due_count  = 0;

    assign errors  = fail_count;
    assign pending = due_count;

    function automatic int unsigned cap_in_use();
        if (cap_reg == '0)
            return 1;
        if (int'(cap_reg) > ENTRIES)
            return ENTRIES;
        return int'(cap_reg);
    endfunction

    // slot s becomes rank 0, everything that was more recent ages by one
    function automatic void make_recent(int s);
        int unsigned old_rank;
        old_rank = slot_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] < old_rank)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic int lru_slot();
        int          best;
        int unsigned best_rank;
        best      = ENTRIES;
        best_rank = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && (best == ENTRIES || slot_rank[i] > best_rank))
            begin
                best      = i;
                best_rank = slot_rank[i];
            end
        return best;
    endfunction

    function automatic int find_key(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return ENTRIES;
    endfunction

    function automatic rsp_t cache_access(req_t w);
        rsp_t        r;
        int          s;
        int          o;
        int          f;
        int unsigned cap;
        cap          = cap_in_use();
        s            = find_key(w.key);
        r.found      = 1'b1;
        r.read_value = '0;
        if (w.command == CMD_GET)
        begin
            if (s < ENTRIES)
            begin
                r.read_value = slot_data[s];
                make_recent(s);
            end
            else
                r.found = 1'b0;
            return r;
        end
        if (s < ENTRIES)
        begin
            slot_data[s] = w.value;
            make_recent(s);
            // shrink by one after the capacity was lowered
            if (slot_fill > cap)
            begin
                o = lru_slot();
                if (o < ENTRIES && o != s)
                begin
                    slot_valid[o] = 1'b0;
                    slot_fill--;
                end
            end
        end
        else if (slot_fill >= cap || slot_fill >= ENTRIES)
        begin
            o = lru_slot();
            if (o < ENTRIES)
            begin
                slot_key[o]  = w.key;
                slot_data[o] = w.value;
                make_recent(o);
            end
        end
        else
        begin
            f = ENTRIES;
            for (int i = 0; i < ENTRIES; i++)
                if (!slot_valid[i] && f == ENTRIES)
                    f = i;
            if (f < ENTRIES)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i])
                        slot_rank[i]++;
                slot_valid[f] = 1'b1;
                slot_key[f]   = w.key;
                slot_data[f]  = w.value;
                slot_rank[f]  = 0;
                slot_fill++;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_data[i]  = '0;
                slot_rank[i]  = 0;
            end
            slot_fill = 0;
            cap_reg   = CAP_RESET;
            rsp_due.delete();
            due_count = 0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (rsp_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word: expected none, actual %h", $time,
                             rsp);
                end
                else
                begin
                    due_word = rsp_due.pop_front();
                    if (done !== 1'b1 || rsp.found !== due_word.found)
                    begin
                        fail_count++;
                        $display("%0t: found mismatch: expected %b, actual %b", $time,
                                 due_word.found, rsp.found);
                    end
                    if (rsp.read_value !== due_word.read_value)
                    begin
                        fail_count++;
                        $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                                 due_word.read_value, rsp.read_value);
                    end
                end
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (start && !busy)
                rsp_due.push_back(cache_access(req));
            due_count = rsp_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lkv_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               errors;
    int               pending;

    logic [KEY_BITS-1:0] key_pool [12];
    int                  pool_n;

    // covers lowering below a full store, zero and above-range settings
    localparam int PHASES = 14;
    localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] =
        '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd2, 4'd9, 4'd7, 4'd3, 4'd6, 4'd5, 4'd8, 4'd12,
          4'd1};

    lru_key_value_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lkv_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic req_t make_word(cmd_t c, logic [KEY_BITS-1:0] k,
                                       logic [VALUE_BITS-1:0] v);
        req_t w;
        w.command = c;
        w.key     = k;
        w.value   = v;
        return w;
    endfunction

    function automatic req_t random_word();
        cmd_t                  c;
        logic [KEY_BITS-1:0]   k;
        logic [VALUE_BITS-1:0] v;
        c = ($urandom_range(0, 99) < 55) ? CMD_GET : CMD_PUT;
        if ($urandom_range(0, 9) == 0)
            k = KEY_BITS'($urandom);
        else
            k = key_pool[$urandom_range(0, pool_n - 1)];
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = '1;
            default: v = VALUE_BITS'($urandom);
        endcase
        return make_word(c, k, v);
    endfunction

    // start stays high across back-to-back words
    task automatic issue(req_t w);
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        start <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [CAP_W-1:0] c, int count, bit with_gaps);
        int n_left;
        int burst;
        int gap;
        set_capacity(c);
        pool_n = $urandom_range(2, 12);
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = KEY_BITS'($urandom);
        n_left = count;
        while (n_left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n_left > 0; k++)
            begin
                issue(random_word());
                n_left--;
            end
            if (with_gaps)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, key and value extremes, update, fill and evict
        issue(make_word(CMD_GET, 16'h0000, 32'h0000_0000));
        issue(make_word(CMD_PUT, 16'h0000, 32'h0000_0000));
        issue(make_word(CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF));
        issue(make_word(CMD_GET, 16'hFFFF, 32'h1234_5678));
        issue(make_word(CMD_GET, 16'h0000, 32'hFFFF_FFFF));
        issue(make_word(CMD_PUT, 16'h0000, 32'hA5A5_A5A5));
        issue(make_word(CMD_GET, 16'h0000, 32'h0000_0000));
        for (int i = 1; i <= 6; i++)
            issue(make_word(CMD_PUT, KEY_BITS'(i), VALUE_BITS'(32'h5A00_0000 + i)));
        issue(make_word(CMD_PUT, 16'h0007, 32'h0BAD_F00D));
        issue(make_word(CMD_GET, 16'hFFFF, 32'h0000_0000));
        issue(make_word(CMD_GET, 16'h0001, 32'h0000_0000));

        // capacity lowered under a full store: updates shrink, inserts replace
        set_capacity(4'd2);
        issue(make_word(CMD_PUT, 16'h0006, 32'h6666_6666));
        issue(make_word(CMD_PUT, 16'h0005, 32'h5555_5555));
        issue(make_word(CMD_GET, 16'h0001, 32'h0000_0000));
        issue(make_word(CMD_PUT, 16'h0009, 32'h9999_9999));
        issue(make_word(CMD_GET, 16'h0006, 32'h0000_0000));

        set_capacity(4'd0);
        issue(make_word(CMD_PUT, 16'h000A, 32'hAAAA_AAAA));
        issue(make_word(CMD_GET, 16'h0006, 32'h0000_0000));
        issue(make_word(CMD_GET, 16'h000A, 32'h0000_0000));
        start <= 1'b0;

        for (int p = 0; p < PHASES; p++)
            run_phase(PHASE_CAP[p], 118, p % 3 != 1);

        drain();
        if (pending != 0)
            $display("%0t: %0d result words never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
